// File: rtl/assert_macros.svh
// Assertion helpers used by the RTL (gmc_core). Clock and active-low reset are passed in.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GMC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GMC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/gmc_pkg.sv
package gmc_pkg;

  typedef enum logic [1:0] {
    MS_IDLE    = 2'd0,
    MS_OPENING = 2'd1,
    MS_CLOSING = 2'd2
  } motion_e;

  typedef enum logic [2:0] {
    ST_STOPPED = 3'd0,
    ST_OPEN    = 3'd1,
    ST_CLOSED  = 3'd2,
    ST_OPENING = 3'd3,
    ST_CLOSING = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FLT_NONE     = 2'd0,
    FLT_TIMEOUT  = 2'd1,
    FLT_LIMITS   = 2'd2,
    FLT_OBSTACLE = 2'd3
  } fault_e;

  typedef enum logic [1:0] {
    CMD_OPEN    = 2'd0,
    CMD_CLOSE   = 2'd1,
    CMD_STOP    = 2'd2,
    CMD_UNKNOWN = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    REG_DEBOUNCE = 2'd0,
    REG_TIMEOUT  = 2'd1,
    REG_RETRY    = 2'd2
  } reg_e;

  // Reported-fault marker: no report has been made yet.
  localparam logic [2:0] FLT_MARKER = 3'd4;

  localparam logic [3:0]  DEBOUNCE_RESET = 4'd3;
  localparam logic [15:0] TIMEOUT_RESET  = 16'd1000;
  localparam logic [15:0] RETRY_RESET    = 16'd250;

  typedef struct packed {
    logic       open_end_raw;
    logic       close_end_raw;
    logic       obstacle_raw;
    logic       button_raw;
    logic       command_valid;
    logic [1:0] command_code;
  } gmc_in_t;

  typedef struct packed {
    logic [1:0] motor_drive;
    logic [2:0] gate_status;
    logic [1:0] fault_code;
    logic       report_pulse;
    logic       command_rejected;
  } gmc_out_t;

  typedef struct packed {
    logic [1:0]  index;
    logic [15:0] data;
  } gmc_cfg_wr_t;

  typedef struct packed {
    logic [3:0]  debounce_count;
    logic [15:0] move_timeout;
    logic [15:0] retry_delay;
  } gmc_cfg_t;

  // Debounced switch levels after this tick's sample.
  typedef struct packed {
    logic open_end;
    logic close_end;
    logic obstacle;
    logic button;
  } gmc_levels_t;

endpackage

// File: rtl/gmc_stream_if.sv
interface gmc_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: rtl/gmc_debounce.sv
module gmc_debounce (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       en_i,
  input  logic       raw_i,
  input  logic [3:0] count_i,
  output logic       level_o
);
  import gmc_pkg::*;

  logic [3:0] active_q, active_d;
  logic [3:0] inactive_q, inactive_d;
  logic       stable_q, stable_d;

  always_comb begin
    active_d   = active_q;
    inactive_d = inactive_q;
    stable_d   = stable_q;
    if (raw_i) begin
      if (active_q < count_i) active_d = active_q + 4'd1;
      inactive_d = '0;
      if (active_d >= count_i) stable_d = 1'b1;
    end else begin
      if (inactive_q < count_i) inactive_d = inactive_q + 4'd1;
      active_d = '0;
      if (inactive_d >= count_i) stable_d = 1'b0;
    end
  end

  assign level_o = stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q   <= '0;
      inactive_q <= DEBOUNCE_RESET;
      stable_q   <= 1'b0;
    end else if (en_i) begin
      active_q   <= active_d;
      inactive_q <= inactive_d;
      stable_q   <= stable_d;
    end
  end
endmodule

// File: rtl/gmc_core.sv
`include "assert_macros.svh"

module gmc_core #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  gmc_pkg::gmc_in_t     item_i,
  input  gmc_pkg::gmc_levels_t levels_i,
  input  gmc_pkg::gmc_cfg_t    cfg_i,
  output gmc_pkg::gmc_out_t    result_o
);
  import gmc_pkg::*;

  localparam int CW = (TIMER_WIDTH > 16) ? TIMER_WIDTH : 16;

  typedef struct packed {
    motion_e    motion;
    logic       next_close;
    status_e    rep_status;
    fault_e     cur_fault;
    logic [2:0] rep_fault;
    logic       retry_pending;
    motion_e    retry_dir;
    logic       mt_clr;
    logic       rt_clr;
    logic       pulse;
  } ctl_t;

  motion_e                motion_q;
  logic                   next_close_q;
  status_e                rep_status_q;
  fault_e                 cur_fault_q;
  logic [2:0]             rep_fault_q;
  logic                   retry_pending_q;
  motion_e                retry_dir_q;
  logic                   button_q;
  logic [TIMER_WIDTH-1:0] move_timer_q, move_timer_d, mt_inc;
  logic [TIMER_WIDTH-1:0] retry_timer_q, retry_timer_d, rt_inc;
  logic                   mt_ge, rt_ge, to_zero, rd_zero;
  logic                   rejected;
  ctl_t                   s;

  function automatic status_e resolve(motion_e m, gmc_levels_t lv);
    if (lv.open_end && lv.close_end) return ST_STOPPED;
    if (lv.open_end) return ST_OPEN;
    if (lv.close_end) return ST_CLOSED;
    if (m == MS_OPENING) return ST_OPENING;
    if (m == MS_CLOSING) return ST_CLOSING;
    return ST_STOPPED;
  endfunction

  function automatic ctl_t refresh(ctl_t c, gmc_levels_t lv);
    status_e st;
    st = resolve(c.motion, lv);
    if (st != c.rep_status || {1'b0, c.cur_fault} != c.rep_fault) begin
      c.rep_fault = {1'b0, c.cur_fault};
      c.pulse     = 1'b1;
    end
    c.rep_status = st;
    return c;
  endfunction

  function automatic ctl_t stop_gate(ctl_t c, gmc_levels_t lv);
    c.motion = MS_IDLE;
    c.mt_clr = 1'b1;
    return refresh(c, lv);
  endfunction

  function automatic ctl_t start_move(ctl_t c, motion_e dir, gmc_levels_t lv);
    logic at_end;
    at_end = (dir == MS_OPENING) ? lv.open_end : lv.close_end;
    if (lv.open_end && lv.close_end) begin
      c.cur_fault = FLT_LIMITS;
      c.motion    = MS_IDLE;
    end else if (at_end) begin
      c.motion = MS_IDLE;
    end else begin
      c.cur_fault  = FLT_NONE;
      c.mt_clr     = 1'b1;
      c.motion     = dir;
      c.next_close = (dir == MS_OPENING);
    end
    return refresh(c, lv);
  endfunction

  function automatic ctl_t cancel_retry(ctl_t c);
    c.retry_pending = 1'b0;
    c.retry_dir     = MS_IDLE;
    c.rt_clr        = 1'b1;
    return c;
  endfunction

  function automatic ctl_t do_command(ctl_t c, cmd_e cmd, gmc_levels_t lv);
    c = cancel_retry(c);
    case (cmd)
      CMD_OPEN:  if (c.motion == MS_IDLE) c = start_move(c, MS_OPENING, lv);
      CMD_CLOSE: if (c.motion == MS_IDLE) c = start_move(c, MS_CLOSING, lv);
      CMD_STOP: begin
        c.cur_fault = FLT_NONE;
        c = stop_gate(c, lv);
      end
      default: ;
    endcase
    return c;
  endfunction

  function automatic ctl_t button_press(ctl_t c, gmc_levels_t lv);
    cmd_e    cmd;
    status_e st;
    cmd = c.next_close ? CMD_CLOSE : CMD_OPEN;
    st  = resolve(c.motion, lv);
    if (c.motion == MS_OPENING) begin
      c.next_close = 1'b1;
      return do_command(c, CMD_STOP, lv);
    end
    if (c.motion == MS_CLOSING) begin
      c.next_close = 1'b0;
      return do_command(c, CMD_STOP, lv);
    end
    if (st == ST_OPEN) cmd = CMD_CLOSE;
    else if (st == ST_CLOSED) cmd = CMD_OPEN;
    return do_command(c, cmd, lv);
  endfunction

  function automatic ctl_t update_motion(ctl_t c, gmc_levels_t lv, logic inc_ge,
                                         logic zero_lim);
    logic moving, ge;
    moving = (c.motion == MS_OPENING) || (c.motion == MS_CLOSING);
    ge     = c.mt_clr ? zero_lim : inc_ge;
    if (lv.open_end && lv.close_end) begin
      c = cancel_retry(c);
      c.cur_fault = FLT_LIMITS;
      if (c.motion != MS_IDLE) c = stop_gate(c, lv);
      else c = refresh(c, lv);
    end else if ((c.motion == MS_OPENING && lv.open_end) ||
                 (c.motion == MS_CLOSING && lv.close_end)) begin
      c = stop_gate(c, lv);
    end else if (moving && lv.obstacle) begin
      c.cur_fault     = FLT_OBSTACLE;
      c.retry_pending = 1'b1;
      c.retry_dir     = c.motion;
      c.rt_clr        = 1'b1;
      c = stop_gate(c, lv);
    end else if (moving && ge) begin
      c.cur_fault = FLT_TIMEOUT;
      c = stop_gate(c, lv);
    end
    return c;
  endfunction

  function automatic ctl_t update_retry(ctl_t c, gmc_levels_t lv, logic inc_ge,
                                        logic zero_lim);
    motion_e dir;
    logic    ge;
    dir = c.retry_dir;
    ge  = c.rt_clr ? zero_lim : inc_ge;
    if (!c.retry_pending || c.motion != MS_IDLE || !ge) return c;
    if (lv.obstacle) begin
      c.rt_clr = 1'b1;
      return c;
    end
    c = cancel_retry(c);
    if (dir == MS_OPENING || dir == MS_CLOSING) c = start_move(c, dir, lv);
    return c;
  endfunction

  // Timers advance first, saturating at all ones.
  assign mt_inc = (motion_q != MS_IDLE && move_timer_q != '1) ?
                  move_timer_q + 1'b1 : move_timer_q;
  assign rt_inc = (retry_pending_q && retry_timer_q != '1) ?
                  retry_timer_q + 1'b1 : retry_timer_q;
  assign mt_ge   = CW'(mt_inc) >= CW'(cfg_i.move_timeout);
  assign rt_ge   = CW'(rt_inc) >= CW'(cfg_i.retry_delay);
  assign to_zero = (cfg_i.move_timeout == '0);
  assign rd_zero = (cfg_i.retry_delay == '0);

  always_comb begin
    s.motion        = motion_q;
    s.next_close    = next_close_q;
    s.rep_status    = rep_status_q;
    s.cur_fault     = cur_fault_q;
    s.rep_fault     = rep_fault_q;
    s.retry_pending = retry_pending_q;
    s.retry_dir     = retry_dir_q;
    s.mt_clr        = 1'b0;
    s.rt_clr        = 1'b0;
    s.pulse         = 1'b0;
    rejected        = 1'b0;

    if (rep_fault_q == FLT_MARKER) s = refresh(s, levels_i);
    if (levels_i.button && !button_q) s = button_press(s, levels_i);

    // Check against the status reported before this tick.
    if (item_i.command_valid) begin
      case (cmd_e'(item_i.command_code))
        CMD_OPEN:  rejected = rep_status_q inside {ST_OPEN, ST_OPENING, ST_CLOSING};
        CMD_CLOSE: rejected = rep_status_q inside {ST_CLOSED, ST_CLOSING, ST_OPENING};
        CMD_STOP:  rejected = 1'b0;
        default:   rejected = 1'b1;
      endcase
      if (!rejected) s = do_command(s, cmd_e'(item_i.command_code), levels_i);
    end

    s = update_motion(s, levels_i, mt_ge, to_zero);
    s = update_retry(s, levels_i, rt_ge, rd_zero);
  end

  assign move_timer_d  = s.mt_clr ? '0 : mt_inc;
  assign retry_timer_d = s.rt_clr ? '0 : rt_inc;

  assign result_o.motor_drive      = s.motion;
  assign result_o.gate_status      = s.rep_status;
  assign result_o.fault_code       = s.cur_fault;
  assign result_o.report_pulse     = s.pulse;
  assign result_o.command_rejected = rejected;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motion_q        <= MS_IDLE;
      next_close_q    <= 1'b0;
      rep_status_q    <= ST_STOPPED;
      cur_fault_q     <= FLT_NONE;
      rep_fault_q     <= FLT_MARKER;
      retry_pending_q <= 1'b0;
      retry_dir_q     <= MS_IDLE;
      button_q        <= 1'b0;
      move_timer_q    <= '0;
      retry_timer_q   <= '0;
    end else if (en_i) begin
      motion_q        <= s.motion;
      next_close_q    <= s.next_close;
      rep_status_q    <= s.rep_status;
      cur_fault_q     <= s.cur_fault;
      rep_fault_q     <= s.rep_fault;
      retry_pending_q <= s.retry_pending;
      retry_dir_q     <= s.retry_dir;
      button_q        <= levels_i.button;
      move_timer_q    <= move_timer_d;
      retry_timer_q   <= retry_timer_d;
    end
  end

  `GMC_ASSERT_IMP(a_retry_idle, clk_i, rst_ni, retry_pending_q, motion_q == MS_IDLE, "retry pending while moving")
  `GMC_ASSERT_IMP(a_move_no_fault, clk_i, rst_ni, motion_q != MS_IDLE, cur_fault_q == FLT_NONE, "fault held while moving")
  `GMC_ASSERT_NXT(a_first_report, clk_i, rst_ni, en_i, rep_fault_q != FLT_MARKER, "startup marker survived a tick")
endmodule

// File: rtl/gate_motion_controller.sv
// Gate motion controller: one poll tick per transfer, one result per tick.
// A tick waits in the input register; its result is offered from the result register.
// Throughput: one tick per cycle while the output is not stalled; the whole tick
// is one combinational pass between the input register and the result register.
// Reset (rst_ni low, asynchronous): gate idle, switches inactive, config at
// debounce 3, timeout 1000, retry delay 250; the first tick always reports.
module gate_motion_controller #(
  parameter int TIMER_WIDTH = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  gmc_stream_if.sink    in_i,
  gmc_stream_if.source  out_o,
  gmc_stream_if.sink    cfg_i
);
  import gmc_pkg::*;

  gmc_in_t     in_q;
  logic        in_valid_q;
  gmc_out_t    out_q;
  logic        out_valid_q;
  gmc_out_t    result;
  gmc_levels_t levels;
  gmc_cfg_t    cfg_q;
  gmc_cfg_wr_t cfg_wr;
  logic        advance;
  logic        in_xfer;

  // Advance the held tick when the result register is free or being drained.
  assign advance = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign in_xfer    = in_i.valid && in_i.ready;

  // Input register: hold a tick until it is processed.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_xfer) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      in_q <= in_i.payload;
    end
  end

  // Configuration: always ready; unknown index is dropped.
  assign cfg_i.ready = 1'b1;
  assign cfg_wr      = cfg_i.payload;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_count <= DEBOUNCE_RESET;
      cfg_q.move_timeout   <= TIMEOUT_RESET;
      cfg_q.retry_delay    <= RETRY_RESET;
    end else if (cfg_i.valid) begin
      case (reg_e'(cfg_wr.index))
        REG_DEBOUNCE: cfg_q.debounce_count <= cfg_wr.data[3:0];
        REG_TIMEOUT:  cfg_q.move_timeout   <= cfg_wr.data;
        REG_RETRY:    cfg_q.retry_delay    <= cfg_wr.data;
        default: ;
      endcase
    end
  end

  // One debounce lane per switch.
  gmc_debounce u_deb_open (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .raw_i   (in_q.open_end_raw),
    .count_i (cfg_q.debounce_count),
    .level_o (levels.open_end)
  );

  gmc_debounce u_deb_close (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .raw_i   (in_q.close_end_raw),
    .count_i (cfg_q.debounce_count),
    .level_o (levels.close_end)
  );

  gmc_debounce u_deb_obst (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .raw_i   (in_q.obstacle_raw),
    .count_i (cfg_q.debounce_count),
    .level_o (levels.obstacle)
  );

  gmc_debounce u_deb_button (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (advance),
    .raw_i   (in_q.button_raw),
    .count_i (cfg_q.debounce_count),
    .level_o (levels.button)
  );

  // Motion, command and report logic with its state.
  gmc_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (advance),
    .item_i   (in_q),
    .levels_i (levels),
    .cfg_i    (cfg_q),
    .result_o (result)
  );

  // Result register: load on advance, drop once the transfer out completes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;
endmodule
